### design/scla_pkg.sv
// Shared constants, codes and types of the serial command line assembler.
// Used by scla_line_ram, scla_take_seq and serial_command_line_assembler.
package scla_pkg;

   localparam int LINE_MAX  = 31;
   localparam int LEN_W     = 5;
   localparam int ADDR_W    = LEN_W + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_W;
   localparam int CNT_W     = 16;
   localparam int LIMIT_W   = 6;

   localparam logic [7:0] LF_BYTE = 8'h0A;
   localparam logic [7:0] CR_BYTE = 8'h0D;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;
   localparam logic [LIMIT_W-1:0] LIMIT_TOP   = 6'd32;
   localparam logic [CNT_W-1:0]   CNT_SAT     = 16'hFFFF;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TAKE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_NO_CMD    = 2'd0,
      ST_CHAR      = 2'd1,
      ST_EMPTY_CMD = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_PRIME,
      SQ_RUN,
      SQ_TAIL,
      SQ_NONE,
      SQ_EMPTY
   } seq_state_type;

   typedef struct packed {
      logic             valid;
      logic             has_cmd;
      logic             bank;
      logic [LEN_W-1:0] max_chars;
   } take_req_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

endpackage

### design/scla_line_ram.sv
// Two-bank character memory holding the line being assembled and the waiting command.
// Depends on scla_pkg; one write port, one read port with registered read data.
module scla_line_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [scla_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic                       rd_en,
   input  logic [scla_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                 rd_data
);
   import scla_pkg::*;

   logic [7:0] mem [RAM_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read data holds while no new read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/scla_take_seq.sv
// Take sequencer: reads the waiting command from memory and streams it out.
// Depends on scla_pkg; drives the memory read port and the result register.
module scla_take_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  scla_pkg::take_req_type      take_req,
   output logic                        idle,
   output scla_pkg::rd_req_type        rd_req,
   input  logic [7:0]                  rd_data,
   input  logic [scla_pkg::CNT_W-1:0]  overflow_count,
   input  logic [scla_pkg::CNT_W-1:0]  busy_drop_count,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [47:0]                 rsp_tdata,  // char_value, char_index,
                                                   // overflow_count, busy_drop_count
   output logic [1:0]                  rsp_tuser,  // status
   output logic                        rsp_tlast
);
   import scla_pkg::*;

   seq_state_type    state_ff, state_in;
   logic [7:0]       cur_ff, cur_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] max_ff, max_in;
   logic             bank_ff, bank_in;

   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [7:0]       rsp_char_ff;
   logic [LEN_W-1:0] rsp_idx_ff;
   logic             rsp_last_ff;
   logic [CNT_W-1:0] rsp_ovf_ff;
   logic [CNT_W-1:0] rsp_busy_ff;

   logic             slot_free;
   logic             emit;
   status_type       emit_status;
   logic [7:0]       emit_char;
   logic [LEN_W-1:0] emit_idx;
   logic             emit_last;
   logic             at_tail;
   logic [LEN_W-1:0] idx_next;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign idle      = (state_ff == SQ_IDLE);
   assign idx_next  = idx_ff + LEN_W'(1);
   // The character after the one now in flight is the final one allowed.
   assign at_tail   = ({1'b0, idx_ff} + (LEN_W+1)'(2)) == {1'b0, max_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SQ_IDLE: begin
            if (take_req.valid) begin
               priority if (!take_req.has_cmd)             state_in = SQ_NONE;
               else if (take_req.max_chars == '0)          state_in = SQ_EMPTY;
               else                                        state_in = SQ_PRIME;
            end
         end
         SQ_PRIME: begin
            priority if (rd_data == 8'd0)                  state_in = SQ_EMPTY;
            else if (max_ff == LEN_W'(1))                  state_in = SQ_TAIL;
            else                                           state_in = SQ_RUN;
         end
         SQ_RUN: begin
            if (slot_free) begin
               priority if (rd_data == 8'd0)               state_in = SQ_IDLE;
               else if (at_tail)                           state_in = SQ_TAIL;
               else                                        state_in = SQ_RUN;
            end
         end
         SQ_TAIL, SQ_NONE, SQ_EMPTY: begin
            if (slot_free) begin
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_comb begin
      rd_req      = '0;
      emit        = 1'b0;
      emit_status = ST_CHAR;
      emit_char   = 8'd0;
      emit_idx    = '0;
      emit_last   = 1'b0;
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      max_in      = max_ff;
      bank_in     = bank_ff;
      unique case (state_ff)
         SQ_IDLE: begin
            max_in  = take_req.max_chars;
            bank_in = take_req.bank;
            if (take_req.valid && take_req.has_cmd && take_req.max_chars != '0) begin
               rd_req.en   = 1'b1;
               rd_req.addr = {take_req.bank, {LEN_W{1'b0}}};
            end
         end
         SQ_PRIME: begin
            cur_in = rd_data;
            idx_in = '0;
            if (rd_data != 8'd0 && max_ff != LEN_W'(1)) begin
               rd_req.en   = 1'b1;
               rd_req.addr = {bank_ff, LEN_W'(1)};
            end
         end
         SQ_RUN: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_char = cur_ff;
               emit_idx  = idx_ff;
               emit_last = (rd_data == 8'd0);
               if (rd_data != 8'd0) begin
                  cur_in = rd_data;
                  idx_in = idx_next;
                  if (!at_tail) begin
                     rd_req.en   = 1'b1;
                     rd_req.addr = {bank_ff, idx_ff + LEN_W'(2)};
                  end
               end
            end
         end
         SQ_TAIL: begin
            emit      = slot_free;
            emit_char = cur_ff;
            emit_idx  = idx_ff;
            emit_last = 1'b1;
         end
         SQ_NONE: begin
            emit        = slot_free;
            emit_status = ST_NO_CMD;
            emit_last   = 1'b1;
         end
         SQ_EMPTY: begin
            emit        = slot_free;
            emit_status = ST_EMPTY_CMD;
            emit_last   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      max_ff  <= max_in;
      bank_ff <= bank_in;
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_char_ff   <= emit_char;
         rsp_idx_ff    <= emit_idx;
         rsp_last_ff   <= emit_last;
         rsp_ovf_ff    <= overflow_count;
         rsp_busy_ff   <= busy_drop_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_busy_ff, rsp_ovf_ff, rsp_idx_ff, rsp_char_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      take_req.valid |-> state_ff == SQ_IDLE)
      else $error("take started while a take is in progress");

   a_run_in_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == SQ_RUN |-> ({1'b0, idx_ff} + (LEN_W+1)'(1)) < {1'b0, max_ff})
      else $error("lookahead read beyond the allowed character count");

   a_last_ends_take: assert property (@(posedge clock) disable iff (reset)
      emit && emit_last |=> state_ff == SQ_IDLE)
      else $error("sequencer kept running after the final result");

endmodule

### design/serial_command_line_assembler.sv
// Top level of the serial command line assembler: byte handling, counters, take limit.
// Depends on scla_pkg, scla_line_ram and scla_take_seq.
//
//   channel | direction | handshake                | payload
//   req     | in        | req_tvalid / req_tready  | tdata byte_value, tuser opcode
//   rsp     | out       | rsp_tvalid / rsp_tready  | tdata char, index, counters;
//           |           |                          | tuser status, tlast last
//   csr     | in        | csr_valid / csr_ready    | csr_data take_limit
//
// A take request of n characters occupies the block: one memory read fetches the first
// character, then one character a cycle while the result is not stalled, with the next
// one read ahead to find the end at a zero byte.
// Reset is synchronous and active high; the character memory needs no clearing.
// Input is not taken while a take is in progress; a stalled result holds the sequencer.
module serial_command_line_assembler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_value
   input  logic [0:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // char_value[7:0], char_index[12:8],
                                    // overflow_count[28:13], busy_drop_count[44:29]
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data     // take_limit
);
   import scla_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic [LEN_W-1:0]   line_len_ff;
   logic               discard_ff;
   logic               line_bank_ff;
   logic [LEN_W-1:0]   cmd_len_ff;
   logic               cmd_ready_ff;
   logic [CNT_W-1:0]   ovf_ff;
   logic [CNT_W-1:0]   busy_ff;

   logic               seq_idle;
   logic               accept;
   logic               is_byte;
   logic               is_take;
   logic [7:0]         rx_byte;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [LIMIT_W-1:0] lim;
   logic [LEN_W-1:0]   lim_chars;
   take_req_type       take_req;
   rd_req_type         rd_req;
   logic [7:0]         rd_data;

   assign csr_ready  = 1'b1;
   assign req_tready = seq_idle;
   assign accept     = req_tvalid && req_tready;
   assign rx_byte    = req_tdata;
   assign is_byte    = accept && (opcode_type'(req_tuser[0]) == OP_BYTE);
   assign is_take    = accept && (opcode_type'(req_tuser[0]) == OP_TAKE);

   assign wr_en   = is_byte && rx_byte != LF_BYTE && rx_byte != CR_BYTE && !discard_ff
                    && (line_len_ff < LEN_W'(LINE_MAX));
   assign wr_addr = {line_bank_ff, line_len_ff};

   always_comb begin
      priority if (limit_ff == '0)       lim = LIMIT_W'(1);
      else if (limit_ff > LIMIT_TOP)     lim = LIMIT_TOP;
      else                               lim = limit_ff;
   end
   assign lim_chars = LEN_W'(lim - LIMIT_W'(1));

   // The command lives in the bank the line is not using.
   always_comb begin
      take_req.valid     = is_take;
      take_req.has_cmd   = cmd_ready_ff;
      take_req.bank      = ~line_bank_ff;
      take_req.max_chars = (lim_chars < cmd_len_ff) ? lim_chars : cmd_len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         line_len_ff  <= '0;
         discard_ff   <= 1'b0;
         line_bank_ff <= 1'b0;
         cmd_len_ff   <= '0;
         cmd_ready_ff <= 1'b0;
         ovf_ff       <= '0;
         busy_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         if (is_take && cmd_ready_ff) begin
            cmd_ready_ff <= 1'b0;
         end
         if (is_byte) begin
            if (rx_byte == LF_BYTE) begin
               if (!discard_ff) begin
                  if (cmd_ready_ff) begin
                     if (busy_ff != CNT_SAT) busy_ff <= busy_ff + CNT_W'(1);
                  end else begin
                     // Handing the line over swaps the banks instead of copying.
                     cmd_len_ff   <= line_len_ff;
                     cmd_ready_ff <= 1'b1;
                     line_bank_ff <= ~line_bank_ff;
                  end
               end
               line_len_ff <= '0;
               discard_ff  <= 1'b0;
            end else if (rx_byte != CR_BYTE && !discard_ff) begin
               if (line_len_ff < LEN_W'(LINE_MAX)) begin
                  line_len_ff <= line_len_ff + LEN_W'(1);
               end else begin
                  if (ovf_ff != CNT_SAT) ovf_ff <= ovf_ff + CNT_W'(1);
                  discard_ff <= 1'b1;
               end
            end
         end
      end
   end

   scla_line_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx_byte),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (rd_data)
   );

   scla_take_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .take_req        (take_req),
      .idle            (seq_idle),
      .rd_req          (rd_req),
      .rd_data         (rd_data),
      .overflow_count  (ovf_ff),
      .busy_drop_count (busy_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast)
   );

   // Writes come only from accepted bytes and reads only during a take.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_req.en))
      else $error("memory written and read in the same cycle");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      line_len_ff <= LEN_W'(LINE_MAX) && cmd_len_ff <= LEN_W'(LINE_MAX))
      else $error("stored length beyond the line capacity");

   a_ovf_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ovf_ff >= $past(ovf_ff) && busy_ff >= $past(busy_ff))
      else $error("saturating counter went down");

endmodule
